@@ rtl/twc_pkg.sv @@
// Shared types, constants and digit helpers for the tilt-wake watch controller.
`timescale 1ns / 1ps

package twc_pkg;

    localparam int ADC_WIDTH = 10;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    localparam logic [2:0] REG_SHORT_PRESS = 3'd0;
    localparam logic [2:0] REG_LONG_PRESS  = 3'd1;
    localparam logic [2:0] REG_AUTO_OFF    = 3'd2;
    localparam logic [2:0] REG_BLINK       = 3'd3;
    localparam logic [2:0] REG_TILT_X_LOW  = 3'd4;
    localparam logic [2:0] REG_TILT_X_HIGH = 3'd5;
    localparam logic [2:0] REG_TILT_Y_MIN  = 3'd6;

    localparam logic [15:0] SHORT_PRESS_RST = 16'd5;
    localparam logic [15:0] LONG_PRESS_RST  = 16'd200;
    localparam logic [7:0]  AUTO_OFF_RST    = 8'd4;
    localparam logic [7:0]  BLINK_RST       = 8'd20;
    localparam logic [ADC_WIDTH-1:0] TILT_X_LOW_RST  = ADC_WIDTH'(478);
    localparam logic [ADC_WIDTH-1:0] TILT_X_HIGH_RST = ADC_WIDTH'(575);
    localparam logic [ADC_WIDTH-1:0] TILT_Y_MIN_RST  = ADC_WIDTH'(500);

    localparam logic [5:0]  MAX_MINSEC  = 6'd59;
    localparam logic [3:0]  MAX_HOUR    = 4'd12;
    localparam logic [7:0]  CNT8_MAX    = 8'hFF;
    localparam logic [15:0] CNT16_MAX   = 16'hFFFF;

    typedef enum logic [2:0] {
        ACT_SECOND  = 3'd0,
        ACT_BUTTON  = 3'd1,
        ACT_PRESS   = 3'd2,
        ACT_REFRESH = 3'd3,
        ACT_ACCEL   = 3'd4
    } act_t;

    typedef enum logic [1:0] {
        MODE_DARK  = 2'd0,
        MODE_SHOW  = 2'd1,
        MODE_SET_H = 2'd2,
        MODE_SET_M = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        POS_HOUR_TENS = 2'd0,
        POS_HOUR_ONES = 2'd1,
        POS_MIN_TENS  = 2'd2,
        POS_MIN_ONES  = 2'd3
    } pos_t;

    typedef struct packed {
        logic [15:0]          short_press_ticks;
        logic [15:0]          long_press_ticks;
        logic [7:0]           auto_off_seconds;
        logic [7:0]           blink_period;
        logic [ADC_WIDTH-1:0] tilt_x_low;
        logic [ADC_WIDTH-1:0] tilt_x_high;
        logic [ADC_WIDTH-1:0] tilt_y_min;
    } cfg_t;

    typedef struct packed {
        logic [2:0]           action;
        logic                 button_down;
        logic [ADC_WIDTH-1:0] accel_x;
        logic [ADC_WIDTH-1:0] accel_y;
    } item_t;

    typedef struct packed {
        logic [1:0] mode_now;
        logic       display_active;
        logic [1:0] digit_select;
        logic [3:0] digit_value;
        logic       digit_show;
        logic       dot_on;
        logic [3:0] clock_hours;
        logic [5:0] clock_minutes;
        logic [5:0] clock_seconds;
    } res_t;

    function automatic logic [3:0] tens6(input logic [5:0] v);
        logic [3:0] q;
        begin
            if (v >= 6'd60)
                q = 4'd6;
            else if (v >= 6'd50)
                q = 4'd5;
            else if (v >= 6'd40)
                q = 4'd4;
            else if (v >= 6'd30)
                q = 4'd3;
            else if (v >= 6'd20)
                q = 4'd2;
            else if (v >= 6'd10)
                q = 4'd1;
            else
                q = 4'd0;
            return q;
        end
    endfunction

    function automatic logic [3:0] ones6(input logic [5:0] v);
        logic [5:0] t;
        logic [5:0] r;
        begin
            t = {2'b00, tens6(v)};
            r = v - (t * 6'd10);
            return r[3:0];
        end
    endfunction

endpackage

@@ rtl/twc_cfg_regs.sv @@
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module twc_cfg_regs
    import twc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_press_ticks <= SHORT_PRESS_RST;
            cfg_reg.long_press_ticks  <= LONG_PRESS_RST;
            cfg_reg.auto_off_seconds  <= AUTO_OFF_RST;
            cfg_reg.blink_period      <= BLINK_RST;
            cfg_reg.tilt_x_low        <= TILT_X_LOW_RST;
            cfg_reg.tilt_x_high       <= TILT_X_HIGH_RST;
            cfg_reg.tilt_y_min        <= TILT_Y_MIN_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SHORT_PRESS: cfg_reg.short_press_ticks <= pwdata[15:0];
                REG_LONG_PRESS:  cfg_reg.long_press_ticks  <= pwdata[15:0];
                REG_AUTO_OFF:    cfg_reg.auto_off_seconds  <= pwdata[7:0];
                REG_BLINK:       cfg_reg.blink_period      <= pwdata[7:0];
                REG_TILT_X_LOW:  cfg_reg.tilt_x_low        <= pwdata[ADC_WIDTH-1:0];
                REG_TILT_X_HIGH: cfg_reg.tilt_x_high       <= pwdata[ADC_WIDTH-1:0];
                REG_TILT_Y_MIN:  cfg_reg.tilt_y_min        <= pwdata[ADC_WIDTH-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SHORT_PRESS: prdata = PDATA_W'(cfg_reg.short_press_ticks);
            REG_LONG_PRESS:  prdata = PDATA_W'(cfg_reg.long_press_ticks);
            REG_AUTO_OFF:    prdata = PDATA_W'(cfg_reg.auto_off_seconds);
            REG_BLINK:       prdata = PDATA_W'(cfg_reg.blink_period);
            REG_TILT_X_LOW:  prdata = PDATA_W'(cfg_reg.tilt_x_low);
            REG_TILT_X_HIGH: prdata = PDATA_W'(cfg_reg.tilt_x_high);
            REG_TILT_Y_MIN:  prdata = PDATA_W'(cfg_reg.tilt_y_min);
            default:         prdata = '0;
        endcase
    end

endmodule

@@ rtl/twc_core.sv @@
// Watch state, event handling and digit scan, one transaction per cycle while step is high.
`timescale 1ns / 1ps

module twc_core
    import twc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    logic [3:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [3:0]  edit_hours_reg, edit_hours_next;
    logic [5:0]  edit_minutes_reg, edit_minutes_next;
    mode_t       mode_reg, mode_next;
    logic [15:0] press_ticks_reg, press_ticks_next;
    logic        press_counting_reg, press_counting_next;
    logic [7:0]  on_seconds_reg, on_seconds_next;
    logic [7:0]  blink_ticks_reg, blink_ticks_next;
    logic        blink_phase_reg, blink_phase_next;
    logic        tilt_cleared_reg, tilt_cleared_next;
    logic [1:0]  scan_position_reg, scan_position_next;
    logic        refresh_enabled_reg, refresh_enabled_next;

    logic [6:0]  sec_inc;
    logic [6:0]  min_inc;
    logic [4:0]  hour_inc;
    logic [7:0]  on_sat;
    logic [7:0]  blink_sat;
    logic [3:0]  eh_inc;
    logic [5:0]  em_inc;
    logic        editing;
    logic        in_window;

    logic [3:0]  h_sel;
    logic [5:0]  m_sel;
    logic [3:0]  v_raw;
    logic        lit;

    assign sec_inc   = {1'b0, second_reg} + 7'd1;
    assign min_inc   = {1'b0, minute_reg} + 7'd1;
    assign hour_inc  = {1'b0, hour_reg} + 5'd1;
    assign on_sat    = (on_seconds_reg == CNT8_MAX) ? CNT8_MAX : on_seconds_reg + 8'd1;
    assign blink_sat = (blink_ticks_reg == CNT8_MAX) ? CNT8_MAX : blink_ticks_reg + 8'd1;
    assign eh_inc    = edit_hours_reg + 4'd1;
    assign em_inc    = edit_minutes_reg + 6'd1;
    assign editing   = (mode_reg == MODE_SET_H) || (mode_reg == MODE_SET_M);
    assign in_window = (item.accel_x > cfg.tilt_x_low) && (item.accel_x < cfg.tilt_x_high)
                       && (item.accel_y > cfg.tilt_y_min);

    // next state
    always_comb
    begin
        hour_next            = hour_reg;
        minute_next          = minute_reg;
        second_next          = second_reg;
        edit_hours_next      = edit_hours_reg;
        edit_minutes_next    = edit_minutes_reg;
        mode_next            = mode_reg;
        press_ticks_next     = press_ticks_reg;
        press_counting_next  = press_counting_reg;
        on_seconds_next      = on_seconds_reg;
        blink_ticks_next     = blink_ticks_reg;
        blink_phase_next     = blink_phase_reg;
        tilt_cleared_next    = tilt_cleared_reg;
        scan_position_next   = scan_position_reg;
        refresh_enabled_next = refresh_enabled_reg;

        case (item.action)
            ACT_SECOND:
            begin
                if (sec_inc > {1'b0, MAX_MINSEC})
                begin
                    second_next = '0;
                    if (min_inc > {1'b0, MAX_MINSEC})
                    begin
                        minute_next = '0;
                        hour_next   = (hour_inc > {1'b0, MAX_HOUR}) ? 4'd1 : hour_inc[3:0];
                    end
                    else
                    begin
                        minute_next = min_inc[5:0];
                    end
                end
                else
                begin
                    second_next = sec_inc[5:0];
                end
                if (mode_reg == MODE_SHOW)
                begin
                    on_seconds_next = on_sat;
                    if (on_sat > cfg.auto_off_seconds)
                    begin
                        mode_next            = MODE_DARK;
                        tilt_cleared_next    = 1'b0;
                        on_seconds_next      = '0;
                        refresh_enabled_next = 1'b0;
                    end
                end
            end
            ACT_BUTTON:
            begin
                if (item.button_down)
                begin
                    press_ticks_next    = '0;
                    press_counting_next = 1'b1;
                end
                else
                begin
                    press_counting_next = 1'b0;
                    if (press_ticks_reg >= cfg.long_press_ticks)
                    begin
                        case (mode_reg)
                            MODE_DARK, MODE_SHOW:
                            begin
                                mode_next            = MODE_SET_M;
                                edit_hours_next      = hour_reg;
                                edit_minutes_next    = minute_reg;
                                on_seconds_next      = '0;
                                blink_phase_next     = 1'b1;
                                refresh_enabled_next = 1'b1;
                            end
                            MODE_SET_M:
                            begin
                                mode_next = MODE_SET_H;
                            end
                            default:
                            begin
                                hour_next            = edit_hours_reg;
                                minute_next          = edit_minutes_reg;
                                second_next          = '0;
                                mode_next            = MODE_SHOW;
                                on_seconds_next      = '0;
                                blink_phase_next     = 1'b1;
                                refresh_enabled_next = 1'b1;
                            end
                        endcase
                    end
                    else if (press_ticks_reg >= cfg.short_press_ticks)
                    begin
                        case (mode_reg)
                            MODE_DARK:
                            begin
                                mode_next            = MODE_SHOW;
                                on_seconds_next      = '0;
                                blink_phase_next     = 1'b1;
                                refresh_enabled_next = 1'b1;
                            end
                            MODE_SHOW:
                            begin
                                mode_next            = MODE_DARK;
                                on_seconds_next      = '0;
                                refresh_enabled_next = 1'b0;
                            end
                            MODE_SET_H:
                            begin
                                edit_hours_next = (eh_inc > MAX_HOUR) ? 4'd1 : eh_inc;
                            end
                            default:
                            begin
                                edit_minutes_next = (em_inc > MAX_MINSEC) ? 6'd0 : em_inc;
                            end
                        endcase
                    end
                end
            end
            ACT_PRESS:
            begin
                if (press_counting_reg && (press_ticks_reg != CNT16_MAX))
                    press_ticks_next = press_ticks_reg + 16'd1;
            end
            ACT_REFRESH:
            begin
                if (refresh_enabled_reg)
                begin
                    scan_position_next = scan_position_reg + 2'd1;
                    if (editing)
                    begin
                        blink_ticks_next = blink_sat;
                        if (blink_sat > cfg.blink_period)
                        begin
                            blink_ticks_next = '0;
                            blink_phase_next = ~blink_phase_reg;
                        end
                    end
                end
            end
            ACT_ACCEL:
            begin
                if (in_window)
                begin
                    if ((mode_reg == MODE_DARK) && tilt_cleared_reg)
                    begin
                        mode_next            = MODE_SHOW;
                        tilt_cleared_next    = 1'b0;
                        on_seconds_next      = '0;
                        blink_phase_next     = 1'b1;
                        refresh_enabled_next = 1'b1;
                    end
                end
                else
                begin
                    if (mode_reg == MODE_SHOW)
                    begin
                        mode_next            = MODE_DARK;
                        on_seconds_next      = '0;
                        refresh_enabled_next = 1'b0;
                    end
                    tilt_cleared_next = 1'b1;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // result
    always_comb
    begin
        h_sel = editing ? edit_hours_reg : hour_reg;
        m_sel = editing ? edit_minutes_reg : minute_reg;
        v_raw = '0;
        lit   = 1'b1;
        case (scan_position_reg)
            POS_HOUR_TENS:
            begin
                v_raw = (h_sel >= 4'd10) ? 4'd1 : 4'd0;
                if (h_sel < 4'd10)
                    lit = 1'b0;
                else if (mode_reg == MODE_SET_H)
                    lit = blink_phase_next;
            end
            POS_HOUR_ONES:
            begin
                v_raw = (h_sel >= 4'd10) ? h_sel - 4'd10 : h_sel;
                if (mode_reg == MODE_SET_H)
                    lit = blink_phase_next;
            end
            POS_MIN_TENS:
            begin
                v_raw = tens6(m_sel);
                if (mode_reg == MODE_SET_M)
                    lit = blink_phase_next;
            end
            default:
            begin
                v_raw = ones6(m_sel);
                if (mode_reg == MODE_SET_M)
                    lit = blink_phase_next;
            end
        endcase

        res.mode_now       = mode_next;
        res.display_active = refresh_enabled_next;
        res.digit_select   = scan_position_reg;
        res.clock_hours    = hour_next;
        res.clock_minutes  = minute_next;
        res.clock_seconds  = second_next;
        if ((item.action == ACT_REFRESH) && refresh_enabled_reg)
        begin
            res.digit_value = lit ? v_raw : 4'd0;
            res.digit_show  = lit;
            res.dot_on      = lit && (scan_position_reg == POS_HOUR_ONES);
        end
        else
        begin
            res.digit_value = '0;
            res.digit_show  = 1'b0;
            res.dot_on      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg            <= MAX_HOUR;
            minute_reg          <= '0;
            second_reg          <= '0;
            edit_hours_reg      <= '0;
            edit_minutes_reg    <= '0;
            mode_reg            <= MODE_DARK;
            press_ticks_reg     <= '0;
            press_counting_reg  <= 1'b0;
            on_seconds_reg      <= '0;
            blink_ticks_reg     <= '0;
            blink_phase_reg     <= 1'b1;
            tilt_cleared_reg    <= 1'b0;
            scan_position_reg   <= '0;
            refresh_enabled_reg <= 1'b0;
        end
        else if (step)
        begin
            hour_reg            <= hour_next;
            minute_reg          <= minute_next;
            second_reg          <= second_next;
            edit_hours_reg      <= edit_hours_next;
            edit_minutes_reg    <= edit_minutes_next;
            mode_reg            <= mode_next;
            press_ticks_reg     <= press_ticks_next;
            press_counting_reg  <= press_counting_next;
            on_seconds_reg      <= on_seconds_next;
            blink_ticks_reg     <= blink_ticks_next;
            blink_phase_reg     <= blink_phase_next;
            tilt_cleared_reg    <= tilt_cleared_next;
            scan_position_reg   <= scan_position_next;
            refresh_enabled_reg <= refresh_enabled_next;
        end
    end

endmodule

@@ rtl/tilt_wake_watch_controller_unit.sv @@
// Top level: input register, watch core, result register and configuration port.
//
// Usage: events arrive on the input channel (in_valid, in_stall, action, button_down,
// accel_x, accel_y); a transaction is taken at a clock edge with in_valid high and
// in_stall low. Each transaction yields exactly one result transaction on the output
// channel (out_valid, out_stall and the result fields), in order.
// The transaction is first held in the input register, then the watch state is
// updated and the result is captured in the output register in the same cycle.
// One transaction is taken per cycle while the output channel is not stalled.
// When out_stall is high the result register holds, the input register can still
// take one more transaction, and in_stall then rises until the result is taken.
// The user writes configuration registers over the APB-style port only while the
// block is idle; the block does not enforce it. pready is always high and reads
// return the register contents. Reset clears the time to 12:00:00 with the display
// off, both channel registers empty and all configuration registers at their defaults.
`timescale 1ns / 1ps

module tilt_wake_watch_controller_unit
    import twc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           action,
    input  logic                 button_down,
    input  logic [ADC_WIDTH-1:0] accel_x,
    input  logic [ADC_WIDTH-1:0] accel_y,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           mode_now,
    output logic                 display_active,
    output logic [1:0]           digit_select,
    output logic [3:0]           digit_value,
    output logic                 digit_show,
    output logic                 dot_on,
    output logic [3:0]           clock_hours,
    output logic [5:0]           clock_minutes,
    output logic [5:0]           clock_seconds,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    cfg_t  cfg;
    item_t item_reg;
    logic  in_valid_reg;
    res_t  res;
    res_t  res_reg;
    logic  out_valid_reg;
    logic  advance;
    logic  step;

    assign advance  = ~out_valid_reg | ~out_stall;
    assign step     = in_valid_reg & advance;
    assign in_stall = in_valid_reg & ~advance;

    twc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    twc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.action      <= action;
            item_reg.button_down <= button_down;
            item_reg.accel_x     <= accel_x;
            item_reg.accel_y     <= accel_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign mode_now       = res_reg.mode_now;
    assign display_active = res_reg.display_active;
    assign digit_select   = res_reg.digit_select;
    assign digit_value    = res_reg.digit_value;
    assign digit_show     = res_reg.digit_show;
    assign dot_on         = res_reg.dot_on;
    assign clock_hours    = res_reg.clock_hours;
    assign clock_minutes  = res_reg.clock_minutes;
    assign clock_seconds  = res_reg.clock_seconds;

endmodule
